FILE: rtl/obb_pkg.sv
// shared widths, types and register codes of the oriented box overlap test
package obb_pkg;

	localparam int COORD_BITS = 20;
	localparam int AXIS_FRAC  = COORD_BITS - 2;
	localparam int VEC_BITS   = 3 * COORD_BITS;

	// clamped half extent, sign bit dropped
	localparam int EXT_W = COORD_BITS - 1;
	// center offset component
	localparam int D_W   = COORD_BITS + 1;
	// per-term products and the dot product sums
	localparam int DA_W  = D_W + COORD_BITS;
	localparam int AB_W  = 2 * COORD_BITS;
	localparam int T_W   = 2 * COORD_BITS + 3;
	localparam int R_W   = 2 * COORD_BITS + 2;
	localparam int AR_W  = 2 * COORD_BITS + 1;
	// T x R is done as two partial products split at SPLIT
	localparam int SPLIT = T_W / 2;
	localparam int TH_W  = T_W - SPLIT;
	localparam int PH_W  = TH_W + R_W;
	localparam int PL_W  = SPLIT + 1 + R_W;
	localparam int TR_W  = T_W + R_W;
	// extent times abs rotation entry
	localparam int ER_W  = EXT_W + AR_W;
	// common compare width for all fifteen axis tests
	localparam int CMP_W = TR_W + AXIS_FRAC + 4;
	localparam int N_TESTS = 15;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_CENTER       = 3'd0,
		REG_A_AXIS_X       = 3'd1,
		REG_A_AXIS_Y       = 3'd2,
		REG_A_AXIS_Z       = 3'd3,
		REG_A_HALF_EXTENTS = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [VEC_BITS-1:0] center;
		logic [VEC_BITS-1:0] axis_x;
		logic [VEC_BITS-1:0] axis_y;
		logic [VEC_BITS-1:0] axis_z;
		logic [VEC_BITS-1:0] half_extents;
	} box_t;

	// rotation, offset in frame of A and clamped extents
	typedef struct packed {
		logic [2:0][T_W-1:0]        t;
		logic [2:0][2:0][R_W-1:0]   r;
		logic [2:0][2:0][AR_W-1:0]  ar;
		logic [2:0][EXT_W-1:0]      ea;
		logic [2:0][EXT_W-1:0]      eb;
	} obb_dots_t;

endpackage

FILE: rtl/obb_if.sv
// channel interfaces: box input, result output and register write port
interface obb_box_if import obb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VEC_BITS-1:0] b_center;
	logic [VEC_BITS-1:0] b_axis_x;
	logic [VEC_BITS-1:0] b_axis_y;
	logic [VEC_BITS-1:0] b_axis_z;
	logic [VEC_BITS-1:0] b_half_extents;

	modport source (output valid, b_center, b_axis_x, b_axis_y, b_axis_z, b_half_extents,
		input ready);
	modport sink (input valid, b_center, b_axis_x, b_axis_y, b_axis_z, b_half_extents,
		output ready);
endinterface

interface obb_res_if ();
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink (input valid, overlap, output ready);
endinterface

interface obb_cfg_if import obb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [VEC_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/obb_dots.sv
// front pipeline: center offset, dot products, rotation matrix and offset in frame of a
module obb_dots import obb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  box_t      box_a,
	input  logic      in_valid,
	output logic      in_ready,
	input  box_t      box_b,
	output logic      out_valid,
	input  logic      out_ready,
	output obb_dots_t dots
);

	function automatic logic signed [COORD_BITS-1:0] vec_comp(
		input logic [VEC_BITS-1:0] v, input int unsigned i);
		return v[i*COORD_BITS +: COORD_BITS];
	endfunction

	// negative half extent reads as zero
	function automatic logic [EXT_W-1:0] ext_comp(
		input logic [VEC_BITS-1:0] v, input int unsigned i);
		logic [COORD_BITS-1:0] c;
		c = v[i*COORD_BITS +: COORD_BITS];
		return c[COORD_BITS-1] ? '0 : c[EXT_W-1:0];
	endfunction

	function automatic logic [VEC_BITS-1:0] axis_of(input box_t b, input int unsigned i);
		case (i)
			0: return b.axis_x;
			1: return b.axis_y;
			default: return b.axis_z;
		endcase
	endfunction

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	logic [2:0][D_W-1:0]      d_s1;
	logic [2:0][VEC_BITS-1:0] bax_s1;
	logic [2:0][EXT_W-1:0]    ea_s1, eb_s1;

	logic [2:0][2:0][DA_W-1:0]      da_c, da_s2;
	logic [2:0][2:0][2:0][AB_W-1:0] ab_c, ab_s2;
	logic [2:0][EXT_W-1:0]          ea_s2, eb_s2;

	obb_dots_t dots_c, dots_s3;
	logic [R_W-1:0] rneg;

	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s3;
	assign dots      = dots_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: offset of centers, extents clamped
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]   <= vec_comp(box_b.center, k) - vec_comp(box_a.center, k);
				bax_s1[k] <= axis_of(box_b, k);
				ea_s1[k]  <= ext_comp(box_a.half_extents, k);
				eb_s1[k]  <= ext_comp(box_b.half_extents, k);
			end
		end
	end

	// stage 2: single products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				da_c[i][k] = $signed(d_s1[k]) * vec_comp(axis_of(box_a, i), k);
				for (int j = 0; j < 3; j++)
					ab_c[i][j][k] = vec_comp(axis_of(box_a, i), k) * vec_comp(bax_s1[j], k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			da_s2 <= da_c;
			ab_s2 <= ab_c;
			ea_s2 <= ea_s1;
			eb_s2 <= eb_s1;
		end
	end

	// stage 3: three-term sums and absolute rotation entries
	always_comb begin
		dots_c.ea = ea_s2;
		dots_c.eb = eb_s2;
		rneg = '0;
		for (int i = 0; i < 3; i++) begin
			dots_c.t[i] = $signed(da_s2[i][0]) + $signed(da_s2[i][1]) + $signed(da_s2[i][2]);
			for (int j = 0; j < 3; j++) begin
				dots_c.r[i][j] = $signed(ab_s2[i][j][0]) + $signed(ab_s2[i][j][1])
					+ $signed(ab_s2[i][j][2]);
				rneg = -dots_c.r[i][j];
				dots_c.ar[i][j] = dots_c.r[i][j][R_W-1] ? rneg[AR_W-1:0]
					: dots_c.r[i][j][AR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) dots_s3 <= dots_c;
	end

endmodule

FILE: rtl/obb_sat.sv
// back pipeline: the fifteen separating-axis tests on a common scale
module obb_sat import obb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  obb_dots_t          dots,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [N_TESTS-1:0] sep
);

	logic v_s4, v_s5, v_s6, v_s7;
	logic en4, en5, en6, en7;

	// ph/pl: [a][b][j] halves of t[a]*r[b][j]
	logic [2:0][2:0][2:0][PH_W-1:0] ph_c, ph_s4;
	logic [2:0][2:0][2:0][PL_W-1:0] pl_c, pl_s4;
	// eaar[x][y][j] = ea[x]*ar[y][j], ebar[i][x][y] = eb[x]*ar[i][y]
	logic [2:0][2:0][2:0][ER_W-1:0] eaar_c, eaar_s4, eaar_s5;
	logic [2:0][2:0][2:0][ER_W-1:0] ebar_c, ebar_s4, ebar_s5;
	logic [2:0][T_W-1:0]            t_s4, t_s5;
	logic [2:0][EXT_W-1:0]          ea_s4, eb_s4, ea_s5, eb_s5;

	logic [2:0][2:0][2:0][TR_W-1:0] tr_c, tr_s5;

	logic [N_TESTS-1:0][CMP_W-1:0] tt_c, tt_s6, rr_c, rr_s6;
	logic [CMP_W-1:0]              tmag;
	logic [N_TESTS-1:0]            sep_c, sep_s7;
	int unsigned p, q, m, n, k;

	assign en7       = !v_s7 || out_ready;
	assign en6       = !v_s6 || en7;
	assign en5       = !v_s5 || en6;
	assign en4       = !v_s4 || en5;
	assign in_ready  = en4;
	assign out_valid = v_s7;
	assign sep       = sep_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stage 4: partial products
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				for (int j = 0; j < 3; j++) begin
					ph_c[a][b][j] = $signed(dots.t[a][T_W-1:SPLIT]) * $signed(dots.r[b][j]);
					pl_c[a][b][j] = $signed({1'b0, dots.t[a][SPLIT-1:0]})
						* $signed(dots.r[b][j]);
					eaar_c[a][b][j] = dots.ea[a] * dots.ar[b][j];
					ebar_c[a][b][j] = dots.eb[b] * dots.ar[a][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			ph_s4   <= ph_c;
			pl_s4   <= pl_c;
			eaar_s4 <= eaar_c;
			ebar_s4 <= ebar_c;
			t_s4    <= dots.t;
			ea_s4   <= dots.ea;
			eb_s4   <= dots.eb;
		end
	end

	// stage 5: full offset-times-rotation products
	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				for (int j = 0; j < 3; j++)
					tr_c[a][b][j] = ($signed(ph_s4[a][b][j]) <<< SPLIT)
						+ $signed(pl_s4[a][b][j]);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			tr_s5   <= tr_c;
			eaar_s5 <= eaar_s4;
			ebar_s5 <= ebar_s4;
			t_s5    <= t_s4;
			ea_s5   <= ea_s4;
			eb_s5   <= eb_s4;
		end
	end

	// stage 6: projected distance and radius of every axis
	always_comb begin
		p = 0; q = 0; m = 0; n = 0; k = 0;
		for (int i = 0; i < 3; i++) begin
			// face axes of a
			tt_c[i] = CMP_W'($signed(t_s5[i]));
			tt_c[i] = tt_c[i] << AXIS_FRAC;
			rr_c[i] = CMP_W'(ea_s5[i]);
			rr_c[i] = (rr_c[i] << (2 * AXIS_FRAC)) + ebar_s5[i][0][0] + ebar_s5[i][1][1]
				+ ebar_s5[i][2][2];
			// face axes of b
			tt_c[3+i] = $signed(tr_s5[0][0][i]) + $signed(tr_s5[1][1][i])
				+ $signed(tr_s5[2][2][i]);
			rr_c[3+i] = eaar_s5[0][0][i] + eaar_s5[1][1][i] + eaar_s5[2][2][i];
			rr_c[3+i] = rr_c[3+i] << AXIS_FRAC;
			rr_c[3+i] = rr_c[3+i] + (CMP_W'(eb_s5[i]) << (3 * AXIS_FRAC));
		end
		// edge cross products a_i x b_j
		for (int i = 0; i < 3; i++) begin
			p = (i == 2) ? 0 : i + 1;
			q = (i == 0) ? 2 : i - 1;
			for (int j = 0; j < 3; j++) begin
				m = (j == 2) ? 0 : j + 1;
				n = (j == 0) ? 2 : j - 1;
				k = 6 + 3 * i + j;
				tt_c[k] = $signed(tr_s5[q][p][j]) - $signed(tr_s5[p][q][j]);
				rr_c[k] = eaar_s5[p][q][j] + eaar_s5[q][p][j] + ebar_s5[i][m][n]
					+ ebar_s5[i][n][m];
				rr_c[k] = rr_c[k] << AXIS_FRAC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			tt_s6 <= tt_c;
			rr_s6 <= rr_c;
		end
	end

	// stage 7: strict compare, touching counts as overlap
	always_comb begin
		tmag = '0;
		for (int i = 0; i < N_TESTS; i++) begin
			tmag = tt_s6[i][CMP_W-1] ? -tt_s6[i] : tt_s6[i];
			sep_c[i] = tmag > rr_s6[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en7) sep_s7 <= sep_c;
	end

endmodule

FILE: rtl/oriented_box_overlap_test_unit.sv
// top level of the oriented box overlap test: box a registers, pipeline and result register
//
// box a (center, three axes, half extents) is loaded through the cfg write channel,
// one 60-bit word per register index; cfg.ready is always high and an unknown
// index is dropped. the user must write registers only while no box pair is in
// flight; the block itself does not enforce this. each word on box_in carries
// box b; each yields one word on res_out whose overlap bit is 1 when the boxes
// intersect or touch and 0 when one of the fifteen separating axes splits them.
// throughput: one box pair per cycle while res_out takes results, set by the
// fully pipelined multiplier array (no unit is shared between items).
// path: from acceptance on box_in to res_out.valid an item passes three
// stages for offset and dot products, four stages for the partial products,
// sums and compares, and the result register.
// each stage holds a valid bit; a stage advances when it or a later stage has
// room, so bubbles collapse and box_in keeps taking words while a result waits.
// when res_out stalls the pipeline fills and then box_in.ready drops; nothing is
// lost or repeated.
// reset clears box a to all zeros and empties the pipeline.
module oriented_box_overlap_test_unit import obb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	obb_cfg_if.sink   cfg,
	obb_box_if.sink   box_in,
	obb_res_if.source res_out
);

	box_t box_a_q;
	box_t box_b;

	obb_dots_t          dots;
	logic               dots_valid, dots_ready;
	logic               sep_valid, sep_ready;
	logic [N_TESTS-1:0] sep;

	logic res_valid_q;
	logic overlap_q;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_a_q <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_A_CENTER:       box_a_q.center       <= cfg.data;
				REG_A_AXIS_X:       box_a_q.axis_x       <= cfg.data;
				REG_A_AXIS_Y:       box_a_q.axis_y       <= cfg.data;
				REG_A_AXIS_Z:       box_a_q.axis_z       <= cfg.data;
				REG_A_HALF_EXTENTS: box_a_q.half_extents <= cfg.data;
				default: ;
			endcase
		end
	end

	assign box_b = '{
		center:       box_in.b_center,
		axis_x:       box_in.b_axis_x,
		axis_y:       box_in.b_axis_y,
		axis_z:       box_in.b_axis_z,
		half_extents: box_in.b_half_extents
	};

	// rotation matrix and center offset in frame of a
	obb_dots u_dots (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_a     (box_a_q),
		.in_valid  (box_in.valid),
		.in_ready  (box_in.ready),
		.box_b     (box_b),
		.out_valid (dots_valid),
		.out_ready (dots_ready),
		.dots      (dots)
	);

	// one flag per axis that separates the boxes
	obb_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dots_valid),
		.in_ready  (dots_ready),
		.dots      (dots),
		.out_valid (sep_valid),
		.out_ready (sep_ready),
		.sep       (sep)
	);

	// result register parts the pipeline from the receiver
	assign sep_ready = !res_valid_q || res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (sep_ready) begin
			res_valid_q <= sep_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sep_ready) overlap_q <= ~|sep;
	end

	assign res_out.valid   = res_valid_q;
	assign res_out.overlap = overlap_q;

endmodule
